>>> hdl/gzhs_pkg.sv
package gzhs_pkg;

    // Magic words, little-endian as they appear on the wire
    localparam logic [15:0] ZIP_MAGIC  = 16'h4b50;
    localparam logic [15:0] GZIP_MAGIC = 16'h8b1f;

    // Zip local header signature tail bytes
    localparam logic [7:0] ZIP_SIG2 = 8'h03;
    localparam logic [7:0] ZIP_SIG3 = 8'h04;

    // Last byte offset of the fixed header after the magic
    localparam logic [4:0] ZIP_HDR_LAST  = 5'd27;
    localparam logic [4:0] GZIP_HDR_LAST = 5'd7;

    // Zip header byte offsets
    localparam logic [4:0] ZOFS_SIG0   = 5'd0;
    localparam logic [4:0] ZOFS_SIG1   = 5'd1;
    localparam logic [4:0] ZOFS_FLAGS  = 5'd4;
    localparam logic [4:0] ZOFS_METH0  = 5'd6;
    localparam logic [4:0] ZOFS_METH1  = 5'd7;
    localparam logic [4:0] ZOFS_SIZE0  = 5'd16;
    localparam logic [4:0] ZOFS_SIZE3  = 5'd19;
    localparam logic [4:0] ZOFS_NAME0  = 5'd24;
    localparam logic [4:0] ZOFS_NAME1  = 5'd25;
    localparam logic [4:0] ZOFS_EXTRA0 = 5'd26;

    // Gzip header byte offsets
    localparam logic [4:0] GOFS_METH  = 5'd0;
    localparam logic [4:0] GOFS_FLAGS = 5'd1;

    // Compression methods
    localparam logic [15:0] METH_STORED  = 16'd0;
    localparam logic [15:0] METH_DEFLATE = 16'd8;
    localparam logic [15:0] METH_GZ_ALT  = 16'd9;

    // Flag bit positions
    localparam int ZFLAG_ENCRYPT  = 0;
    localparam int GFLAG_MULTI    = 1;
    localparam int GFLAG_EXTRA    = 2;
    localparam int GFLAG_NAME     = 3;
    localparam int GFLAG_COMMENT  = 4;
    localparam int GFLAG_ENCRYPT  = 5;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_ZIP_HDR   = 3'd2;
    localparam logic [2:0] ERR_ZIP_METH  = 3'd3;
    localparam logic [2:0] ERR_GZ_METH   = 3'd4;
    localparam logic [2:0] ERR_MULTIPART = 3'd5;
    localparam logic [2:0] ERR_ENCRYPTED = 3'd6;
    localparam logic [2:0] ERR_GZ_SHORT  = 3'd7;

    // Parser phase
    typedef enum logic [3:0] {
        PH_MAG0     = 4'd0,
        PH_MAG1     = 4'd1,
        PH_ZHDR     = 4'd2,
        PH_ZNAME    = 4'd3,
        PH_ZEXTRA   = 4'd4,
        PH_ZDATA    = 4'd5,
        PH_GHDR     = 4'd6,
        PH_GXLEN    = 4'd7,
        PH_GXSKIP   = 4'd8,
        PH_GNAME    = 4'd9,
        PH_GCOMMENT = 4'd10,
        PH_GDATA    = 4'd11,
        PH_DRAIN    = 4'd12
    } t_phase;

    // Input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_item;

    // Result request
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       is_deflate;
        logic       is_gzip;
        logic       last;
    } t_result;

    // Handshake between the input register and the parser
    typedef struct packed {
        logic valid;
        logic take;
    } t_stage_ctl;

endpackage

>>> hdl/gzhs_in_reg.sv
module gzhs_in_reg
    import gzhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_item      i_data,
    input  logic       i_take,
    output logic       o_valid,
    output t_item      o_data
);

    logic  r_valid;
    t_item r_data;

    // Hold a request until the parser takes it
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

>>> hdl/gzhs_parser.sv
module gzhs_parser
    import gzhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_item      i_item,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef struct packed {
        logic        done;
        t_phase      ph;
        logic        ld_skip;
        logic [15:0] skip;
    } t_zadv;

    // Next zip section after the fixed header (from=0), name (from=1) or extra (from=2)
    function automatic t_zadv zip_advance(input logic [1:0] from, input logic [15:0] nlen,
                                          input logic [15:0] xlen, input logic [31:0] pay,
                                          input t_phase cur);
        t_zadv a;
        a.done = 1'b0; a.ph = cur; a.ld_skip = 1'b0; a.skip = 16'd0;
        if (from < 2'd1 && nlen != 16'd0) begin
            a.ph = PH_ZNAME; a.ld_skip = 1'b1; a.skip = nlen;
        end else if (from < 2'd2 && xlen != 16'd0) begin
            a.ph = PH_ZEXTRA; a.ld_skip = 1'b1; a.skip = xlen;
        end else if (pay != 32'd0) begin
            a.ph = PH_ZDATA;
        end else begin
            a.done = 1'b1;
        end
        return a;
    endfunction

    // Next gzip section after the fixed header, extra, name or comment
    function automatic t_phase gzip_advance(input logic [1:0] from, input logic [7:0] flg);
        t_phase p;
        if (from < 2'd1 && flg[GFLAG_EXTRA]) begin
            p = PH_GXLEN;
        end else if (from < 2'd2 && flg[GFLAG_NAME]) begin
            p = PH_GNAME;
        end else if (from < 2'd3 && flg[GFLAG_COMMENT]) begin
            p = PH_GCOMMENT;
        end else begin
            p = PH_GDATA;
        end
        return p;
    endfunction

    t_phase      r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [7:0]  r_magic_low, n_magic_low;
    logic [7:0]  r_flag, n_flag;
    logic [15:0] r_method, n_method;
    logic [15:0] r_name_len, n_name_len;
    logic [15:0] r_extra_len, n_extra_len;
    logic [15:0] r_skip, n_skip;
    logic [31:0] r_pay, n_pay;
    logic        r_gz, n_gz;

    logic        take;
    logic [7:0]  b;
    logic        eos;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        fail_gz;
    logic        fall;
    t_zadv       za;
    logic        res_valid;
    t_result     res;

    assign take = i_ctl.valid && i_ctl.take;
    assign b    = i_item.in_byte;
    assign eos  = i_item.end_of_stream;

    // One step of the container parser per accepted byte
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_magic_low = r_magic_low;
        n_flag      = r_flag;
        n_method    = r_method;
        n_name_len  = r_name_len;
        n_extra_len = r_extra_len;
        n_skip      = r_skip;
        n_pay       = r_pay;
        n_gz        = r_gz;
        fail_en     = 1'b0;
        fail_code   = ERR_NONE;
        fail_gz     = 1'b0;
        fall        = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        za          = '0;

        case (r_phase)
            PH_MAG0: begin
                n_magic_low = b;
                if (eos) begin
                    fail_en = 1'b1; fail_code = ERR_MAGIC;
                end else begin
                    n_phase = PH_MAG1;
                end
            end
            PH_MAG1: begin
                n_cnt = 5'd0;
                if ({b, r_magic_low} == ZIP_MAGIC) begin
                    n_gz = 1'b0; n_phase = PH_ZHDR;
                    if (eos) begin
                        fail_en = 1'b1; fail_code = ERR_ZIP_HDR;
                    end
                end else if ({b, r_magic_low} == GZIP_MAGIC) begin
                    n_gz = 1'b1; n_phase = PH_GHDR;
                    if (eos) begin
                        fail_en = 1'b1; fail_code = ERR_GZ_SHORT; fail_gz = 1'b1;
                    end
                end else begin
                    n_gz = 1'b0;
                    fail_en = 1'b1; fail_code = ERR_MAGIC;
                end
            end
            PH_ZHDR: begin
                if ((r_cnt == ZOFS_SIG0 && b != ZIP_SIG2) ||
                    (r_cnt == ZOFS_SIG1 && b != ZIP_SIG3)) begin
                    fail_en = 1'b1; fail_code = ERR_ZIP_HDR;
                end else begin
                    // capture header fields by offset
                    if (r_cnt == ZOFS_FLAGS) n_flag = b;
                    if (r_cnt == ZOFS_METH0) n_method[7:0] = b;
                    if (r_cnt == ZOFS_METH1) n_method[15:8] = b;
                    if (r_cnt >= ZOFS_SIZE0 && r_cnt <= ZOFS_SIZE3) begin
                        n_pay[{r_cnt[1:0], 3'b000} +: 8] = b;
                    end
                    if (r_cnt == ZOFS_NAME0) n_name_len[7:0] = b;
                    if (r_cnt == ZOFS_NAME1) n_name_len[15:8] = b;
                    if (r_cnt == ZOFS_EXTRA0) n_extra_len[7:0] = b;
                    if (r_cnt < ZIP_HDR_LAST) begin
                        n_cnt = r_cnt + 5'd1;
                        if (eos) begin
                            fail_en = 1'b1; fail_code = ERR_ZIP_HDR;
                        end
                    end else begin
                        n_extra_len[15:8] = b;
                        if (n_method != METH_STORED && n_method != METH_DEFLATE) begin
                            fail_en = 1'b1; fail_code = ERR_ZIP_METH;
                        end else if (n_flag[ZFLAG_ENCRYPT]) begin
                            fail_en = 1'b1; fail_code = ERR_ENCRYPTED;
                        end else begin
                            za = zip_advance(2'd0, n_name_len, n_extra_len, n_pay, r_phase);
                            if (za.done) begin
                                res_valid = 1'b1;
                                res = '{8'd0, KIND_EMPTY, ERR_NONE, (n_method != METH_STORED),
                                        1'b0, 1'b1};
                                n_phase = eos ? PH_MAG0 : PH_DRAIN;
                            end else begin
                                n_phase = za.ph;
                                if (za.ld_skip) n_skip = za.skip;
                                fall = 1'b1;
                            end
                        end
                    end
                end
            end
            PH_ZNAME, PH_ZEXTRA: begin
                n_skip = r_skip - 16'd1;
                fall = 1'b1;
                if (n_skip == 16'd0) begin
                    za = zip_advance((r_phase == PH_ZNAME) ? 2'd1 : 2'd2, r_name_len,
                                     r_extra_len, r_pay, r_phase);
                    if (za.done) begin
                        fall = 1'b0;
                        res_valid = 1'b1;
                        res = '{8'd0, KIND_EMPTY, ERR_NONE, (r_method != METH_STORED),
                                1'b0, 1'b1};
                        n_phase = eos ? PH_MAG0 : PH_DRAIN;
                    end else begin
                        n_phase = za.ph;
                        if (za.ld_skip) n_skip = za.skip;
                    end
                end
            end
            PH_ZDATA: begin
                if (r_pay != 32'd0) n_pay = r_pay - 32'd1;
                res_valid = 1'b1;
                res = '{b, KIND_DATA, ERR_NONE, (r_method != METH_STORED), 1'b0,
                        (eos || r_pay <= 32'd1)};
                if (eos || r_pay <= 32'd1) n_phase = eos ? PH_MAG0 : PH_DRAIN;
            end
            PH_GHDR: begin
                if (r_cnt == GOFS_METH) n_method = {8'd0, b};
                if (r_cnt == GOFS_FLAGS) n_flag = b;
                if (r_cnt < GZIP_HDR_LAST) begin
                    n_cnt = r_cnt + 5'd1;
                    if (eos) begin
                        fail_en = 1'b1; fail_code = ERR_GZ_SHORT; fail_gz = 1'b1;
                    end
                end else if (n_method != METH_DEFLATE && n_method != METH_GZ_ALT) begin
                    fail_en = 1'b1; fail_code = ERR_GZ_METH; fail_gz = 1'b1;
                end else if (n_flag[GFLAG_MULTI]) begin
                    fail_en = 1'b1; fail_code = ERR_MULTIPART; fail_gz = 1'b1;
                end else if (n_flag[GFLAG_ENCRYPT]) begin
                    fail_en = 1'b1; fail_code = ERR_ENCRYPTED; fail_gz = 1'b1;
                end else begin
                    n_phase = gzip_advance(2'd0, n_flag);
                    if (n_phase == PH_GXLEN) n_cnt = 5'd0;
                    fall = 1'b1;
                end
            end
            PH_GXLEN: begin
                fall = 1'b1;
                if (r_cnt == 5'd0) begin
                    n_extra_len = {8'd0, b};
                    n_cnt = 5'd1;
                end else begin
                    n_extra_len[15:8] = b;
                    if (n_extra_len != 16'd0) begin
                        n_phase = PH_GXSKIP; n_skip = n_extra_len;
                    end else begin
                        n_phase = gzip_advance(2'd1, r_flag);
                    end
                end
            end
            PH_GXSKIP: begin
                fall = 1'b1;
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) n_phase = gzip_advance(2'd1, r_flag);
            end
            PH_GNAME: begin
                fall = 1'b1;
                if (b == 8'd0) n_phase = gzip_advance(2'd2, r_flag);
            end
            PH_GCOMMENT: begin
                fall = 1'b1;
                if (b == 8'd0) n_phase = gzip_advance(2'd3, r_flag);
            end
            PH_GDATA: begin
                res_valid = 1'b1;
                res = '{b, KIND_DATA, ERR_NONE, 1'b1, 1'b1, eos};
                if (eos) n_phase = PH_MAG0;
            end
            default: begin
                // drain to end of stream
                if (eos) n_phase = PH_MAG0;
            end
        endcase

        // Error result closes the stream
        if (fail_en) begin
            res_valid = 1'b1;
            res = '{8'd0, KIND_ERROR, fail_code, 1'b0, fail_gz, 1'b1};
            n_phase = eos ? PH_MAG0 : PH_DRAIN;
        end else if (fall && eos) begin
            // stream ended inside the header sections
            res_valid = 1'b1;
            res = '{8'd0, KIND_EMPTY, ERR_NONE, (r_gz || n_method != METH_STORED), r_gz, 1'b1};
            n_phase = PH_MAG0;
        end
    end

    assign o_res_valid = take && res_valid;
    assign o_res       = res;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAG0;
            r_cnt   <= 5'd0;
            r_gz    <= 1'b0;
        end else if (take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_gz    <= n_gz;
        end
    end

    // Header fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_low <= 8'd0;
            r_flag      <= 8'd0;
            r_method    <= 16'd0;
            r_name_len  <= 16'd0;
            r_extra_len <= 16'd0;
            r_skip      <= 16'd0;
            r_pay       <= 32'd0;
        end else if (take) begin
            r_magic_low <= n_magic_low;
            r_flag      <= n_flag;
            r_method    <= n_method;
            r_name_len  <= n_name_len;
            r_extra_len <= n_extra_len;
            r_skip      <= n_skip;
            r_pay       <= n_pay;
        end
    end

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == KIND_ERROR |-> o_res.last && !o_res.is_deflate)
        else $error("error result not marked last");

    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_phase == PH_DRAIN |-> !o_res_valid)
        else $error("result emitted while draining");

    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && eos |=> r_phase == PH_MAG0)
        else $error("stream end did not return to magic");

    a_data_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind != KIND_ERROR |-> o_res.error_code == ERR_NONE)
        else $error("error code on non-error result");

endmodule

>>> hdl/gzhs_out_reg.sv
module gzhs_out_reg
    import gzhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;

    // Register is free when empty or being taken this cycle
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_data <= i_res;
        end
    end

endmodule

>>> hdl/zip_gzip_header_stripper_top.sv
// Zip / gzip container header stripper.
// Input channel: one container byte per request (in_byte, end_of_stream),
//   taken when i_in_valid is high and o_in_stall is low.
// Output channel: zero or one result per input byte (payload byte, empty
//   end or error code), offered on o_out_valid, taken when i_out_stall is low.
// Headers are parsed and skipped; payload bytes pass through tagged as
//   stored or deflate. Errors and empty ends carry last and close the stream;
//   remaining bytes are dropped up to end_of_stream.
// A taken byte sits in the input register; the combinational parser step
//   then loads its result, if any, into the result register.
// Throughput: one byte per cycle while the result register can accept; the
//   combinational parser step updates all header state between the two registers.
// While a held result is stalled, an empty input register still takes one byte;
//   o_in_stall is high whenever it holds a byte, until the result is drained.
// Reset (synchronous, active low) empties both registers and returns the
//   parser to the first magic byte with all header fields cleared.
module zip_gzip_header_stripper_top
    import gzhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_item   i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data
);

    t_stage_ctl ctl;
    logic       stage_valid;
    t_item      stage_item;
    logic       out_ready;
    logic       res_valid;
    t_result    res;

    gzhs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_take  (out_ready),
        .o_valid (stage_valid),
        .o_data  (stage_item)
    );

    // Parser advances when the input register holds a byte and the result register can accept
    assign ctl = '{valid: stage_valid, take: out_ready};

    gzhs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    gzhs_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
